### sv/sfpd_pkg.sv
package sfpd_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0] SYNC_FIRST = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam logic [7:0] END_SECOND = 8'hAA;

  localparam logic [7:0] END_FIRST_RST = 8'h55;
  localparam logic [15:0] IDLE_LIMIT_RST = 16'd50;

  localparam logic [CFG_IDX_W-1:0] REG_END_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 2'd1;

  typedef enum logic [3:0] {
    ST_SYNC1   = 4'd0,
    ST_SYNC2   = 4'd1,
    ST_DST     = 4'd2,
    ST_SRC     = 4'd3,
    ST_CLASS   = 4'd4,
    ST_OPC     = 4'd5,
    ST_FLAGS   = 4'd6,
    ST_SEQ     = 4'd7,
    ST_LEN_L   = 4'd8,
    ST_LEN_H   = 4'd9,
    ST_PAYLOAD = 4'd10,
    ST_CK_A    = 4'd11,
    ST_CK_B    = 4'd12,
    ST_END1    = 4'd13,
    ST_END2    = 4'd14
  } pstate_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] dest_addr;
    logic [7:0] source_addr;
    logic [7:0] frame_class;
    logic [7:0] frame_opcode;
    logic [7:0] frame_flags;
    logic [7:0] frame_seq;
    logic [8:0] payload_length;
  } result_t;

  typedef struct packed {
    logic main_full;
    logic skid_full;
  } buf_status_t;

endpackage

### sv/sfpd_parser.sv
module sfpd_parser #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic               op,
  input  logic [7:0]         data_byte,
  input  logic [7:0]         end_marker_first,
  input  logic [15:0]        idle_limit_ticks,
  output logic               res_push,
  output sfpd_pkg::result_t  res
);
  import sfpd_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

  pstate_t          state, state_next;
  logic [7:0]       hdr [6];
  logic [7:0]       hdr_next [6];
  logic [15:0]      length_reg, length_reg_next;
  logic [CNT_W-1:0] payload_count, payload_count_next;
  logic [CNT_W-1:0] cnt_inc;
  logic [7:0]       sum_a, sum_a_next;
  logic [7:0]       sum_b, sum_b_next;
  logic [7:0]       check_a, check_a_next;
  logic [15:0]      silence_count, silence_count_next;
  logic [15:0]      len_full;
  logic [15:0]      cnt_wide;
  logic [7:0]       sa_add, sb_add;
  logic             started;
  logic             fail;
  logic             emit_discard;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SYNC1;
      payload_count <= '0;
      sum_a         <= '0;
      sum_b         <= '0;
      silence_count <= '0;
    end else if (take) begin
      state         <= state_next;
      payload_count <= payload_count_next;
      sum_a         <= sum_a_next;
      sum_b         <= sum_b_next;
      silence_count <= silence_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hdr        <= hdr_next;
      length_reg <= length_reg_next;
      check_a    <= check_a_next;
    end
  end

  assign sa_add   = sum_a + data_byte;
  assign sb_add   = sum_b + sa_add;
  assign len_full = {data_byte, length_reg[7:0]};
  assign cnt_inc  = payload_count + 1'b1;
  assign cnt_wide = 16'(payload_count);
  assign started  = (state >= ST_PAYLOAD) && (state <= ST_END2) && (payload_count != '0);

  always_comb begin
    state_next         = state;
    hdr_next           = hdr;
    length_reg_next    = length_reg;
    payload_count_next = payload_count;
    sum_a_next         = sum_a;
    sum_b_next         = sum_b;
    check_a_next       = check_a;
    silence_count_next = '0;
    fail               = 1'b0;
    emit_discard       = 1'b0;
    res_push           = 1'b0;
    res                = '0;

    if (op) begin
      silence_count_next = (silence_count == 16'hFFFF) ? silence_count
                                                       : silence_count + 16'd1;
      // drop a partial frame once silence runs past the limit
      if (state != ST_SYNC1 && silence_count_next > idle_limit_ticks) begin
        emit_discard = started;
        state_next   = ST_SYNC1;
      end
    end else begin
      unique case (state)
        ST_SYNC1: begin
          if (data_byte == SYNC_FIRST) state_next = ST_SYNC2;
        end
        ST_SYNC2: begin
          if (data_byte == SYNC_SECOND) begin
            sum_a_next         = '0;
            sum_b_next         = '0;
            payload_count_next = '0;
            state_next         = ST_DST;
          end else begin
            fail = 1'b1;
          end
        end
        ST_DST, ST_SRC, ST_CLASS, ST_OPC, ST_FLAGS, ST_SEQ: begin
          sum_a_next = sa_add;
          sum_b_next = sb_add;
          unique case (state)
            ST_DST:   begin hdr_next[0] = data_byte; state_next = ST_SRC;   end
            ST_SRC:   begin hdr_next[1] = data_byte; state_next = ST_CLASS; end
            ST_CLASS: begin hdr_next[2] = data_byte; state_next = ST_OPC;   end
            ST_OPC:   begin hdr_next[3] = data_byte; state_next = ST_FLAGS; end
            ST_FLAGS: begin hdr_next[4] = data_byte; state_next = ST_SEQ;   end
            default:  begin hdr_next[5] = data_byte; state_next = ST_LEN_L; end
          endcase
        end
        ST_LEN_L: begin
          length_reg_next = {8'h00, data_byte};
          sum_a_next      = sa_add;
          sum_b_next      = sb_add;
          state_next      = ST_LEN_H;
        end
        ST_LEN_H: begin
          length_reg_next = len_full;
          sum_a_next      = sa_add;
          sum_b_next      = sb_add;
          if (len_full > 16'(MAX_PAYLOAD)) fail = 1'b1;
          else if (len_full == 16'd0) state_next = ST_CK_A;
          else state_next = ST_PAYLOAD;
        end
        ST_PAYLOAD: begin
          res_push            = 1'b1;
          res.kind            = KIND_PAYLOAD;
          res.payload_byte    = data_byte;
          res.payload_index   = cnt_wide[7:0];
          payload_count_next  = cnt_inc;
          sum_a_next          = sa_add;
          sum_b_next          = sb_add;
          if (16'(cnt_inc) >= length_reg) state_next = ST_CK_A;
        end
        ST_CK_A: begin
          check_a_next = data_byte;
          state_next   = ST_CK_B;
        end
        ST_CK_B: begin
          if (check_a == sum_a && data_byte == sum_b) state_next = ST_END1;
          else fail = 1'b1;
        end
        ST_END1: begin
          if (data_byte == end_marker_first) state_next = ST_END2;
          else fail = 1'b1;
        end
        ST_END2: begin
          if (data_byte == END_SECOND) begin
            res_push           = 1'b1;
            res.kind           = KIND_ACCEPT;
            res.dest_addr      = hdr[0];
            res.source_addr    = hdr[1];
            res.frame_class    = hdr[2];
            res.frame_opcode   = hdr[3];
            res.frame_flags    = hdr[4];
            res.frame_seq      = hdr[5];
            res.payload_length = length_reg[8:0];
            state_next         = ST_SYNC1;
          end else begin
            fail = 1'b1;
          end
        end
        default: state_next = ST_SYNC1;
      endcase

      // re-test a failed byte as the first sync byte
      if (fail) begin
        emit_discard = started;
        state_next   = (data_byte == SYNC_FIRST) ? ST_SYNC2 : ST_SYNC1;
      end
    end

    if (emit_discard) begin
      res_push = 1'b1;
      res      = '0;
      res.kind = KIND_DISCARD;
    end
  end

endmodule

### sv/sfpd_out_buf.sv
module sfpd_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sfpd_pkg::result_t     din,
  input  logic                  out_stall,
  output logic                  out_valid,
  output sfpd_pkg::result_t     dout,
  output sfpd_pkg::buf_status_t status
);
  import sfpd_pkg::*;

  logic    main_full, skid_full;
  result_t main_q, skid_q;
  logic    pop;

  assign pop = main_full && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_full <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      // upstream is held while the skid stage is occupied
      if (pop) skid_full <= 1'b0;
    end else if (push) begin
      if (main_full && !pop) skid_full <= 1'b1;
      else main_full <= 1'b1;
    end else if (pop) begin
      main_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (pop) main_q <= skid_q;
    end else if (push) begin
      if (main_full && !pop) skid_q <= din;
      else main_q <= din;
    end
  end

  assign out_valid        = main_full;
  assign dout             = main_q;
  assign status.main_full = main_full;
  assign status.skid_full = skid_full;

endmodule

### sv/sync_framed_packet_deframer.sv
// Channel   Handshake               Payload
// in        in_valid / in_stall     op, data_byte
// out       out_valid / out_stall   kind, payload_byte, payload_index, dest_addr,
//                                   source_addr, frame_class, frame_opcode,
//                                   frame_flags, frame_seq, payload_length
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item is taken per cycle while in_stall is low; the parse state, sums and counters
// update at the accepting edge; any result is registered in the output buffer for out.
// The rate is set by the combinational parse step feeding a two-entry output buffer.
// rst is synchronous: the parser hunts for the first sync byte, buffers empty,
// registers return to end marker 0x55 and idle limit 50.
// in_stall rises only when both output entries are full; cfg_ready is always high.
module sync_framed_packet_deframer #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           op,
  input  logic [7:0]                     data_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     kind,
  output logic [7:0]                     payload_byte,
  output logic [7:0]                     payload_index,
  output logic [7:0]                     dest_addr,
  output logic [7:0]                     source_addr,
  output logic [7:0]                     frame_class,
  output logic [7:0]                     frame_opcode,
  output logic [7:0]                     frame_flags,
  output logic [7:0]                     frame_seq,
  output logic [8:0]                     payload_length,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfpd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sfpd_pkg::*;

  logic        take;
  logic        res_push;
  result_t     res, out_res;
  buf_status_t status;
  logic [7:0]  end_marker_first;
  logic [15:0] idle_limit_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_marker_first <= END_FIRST_RST;
      idle_limit_ticks <= IDLE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_END_FIRST:  end_marker_first <= cfg_data[7:0];
        REG_IDLE_LIMIT: idle_limit_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign take = in_valid && !in_stall;

  sfpd_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .op               (op),
    .data_byte        (data_byte),
    .end_marker_first (end_marker_first),
    .idle_limit_ticks (idle_limit_ticks),
    .res_push         (res_push),
    .res              (res)
  );

  sfpd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_push),
    .din       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .dout      (out_res),
    .status    (status)
  );

  assign in_stall       = status.skid_full;
  assign kind           = out_res.kind;
  assign payload_byte   = out_res.payload_byte;
  assign payload_index  = out_res.payload_index;
  assign dest_addr      = out_res.dest_addr;
  assign source_addr    = out_res.source_addr;
  assign frame_class    = out_res.frame_class;
  assign frame_opcode   = out_res.frame_opcode;
  assign frame_flags    = out_res.frame_flags;
  assign frame_seq      = out_res.frame_seq;
  assign payload_length = out_res.payload_length;

  // the skid entry is only ever filled behind a full main entry
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    status.skid_full |-> status.main_full)
    else $error("skid entry full while main entry empty");

  // a draining output never lets the input side fall into stall
  a_no_stall_on_drain: assert property (@(posedge clk) disable iff (rst)
    (!in_stall && out_valid && !out_stall) |=> !in_stall)
    else $error("input stalled after output drained");

  // a result pushed into an empty buffer shows up on the next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (take && res_push && !out_valid) |=> out_valid)
    else $error("pushed result not presented");

endmodule
